### hw/rtl/rbd_pkg.sv
// Package for the 2x2 RGB box downsampler: widths, register codes and
// the per-channel add functions shared by the datapath modules.
// Depends on nothing.
`default_nettype none

package rbd_pkg;

    // Field and port widths.
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int PAIR_W     = 9;
    localparam int PIX_W      = CH_W * NUM_CH;
    localparam int PAIRS_W    = PAIR_W * NUM_CH;
    localparam int HW_W       = 11;
    localparam int HH_W       = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    // Default depth of the line store, in output columns.
    localparam int DEF_MAX_HALF_WIDTH = 1024;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HALF_WIDTH  = 1'b0,
        CFG_HALF_HEIGHT = 1'b1
    } cfg_reg_t;

    // Position of the item being accepted, as seen by the datapath.
    typedef struct packed {
        logic odd_col;
        logic odd_row;
        logic last_out;
    } rbd_pos_t;

    // Adds one pixel to a set of horizontal pair sums, channel by channel.
    function automatic logic [PAIRS_W-1:0] pair_add(input logic [PAIRS_W-1:0] pairs,
                                                    input logic [PIX_W-1:0] pix);
        logic [PAIRS_W-1:0] res;
        res = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            res[c*PAIR_W +: PAIR_W] = pairs[c*PAIR_W +: PAIR_W]
                                      + PAIR_W'(pix[c*CH_W +: CH_W]);
        end
        return res;
    endfunction

    // Widens a pixel into pair-sum format.
    function automatic logic [PAIRS_W-1:0] pix_to_pairs(input logic [PIX_W-1:0] pix);
        logic [PAIRS_W-1:0] res;
        res = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            res[c*PAIR_W +: PAIR_W] = PAIR_W'(pix[c*CH_W +: CH_W]);
        end
        return res;
    endfunction

    // Sums an upper and a lower pair per channel and divides by four.
    function automatic logic [PIX_W-1:0] box_avg(input logic [PAIRS_W-1:0] upper,
                                                 input logic [PAIRS_W-1:0] lower);
        logic [PIX_W-1:0]  res;
        logic [PAIR_W:0]   sum;
        res = '0;
        sum = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            sum = {1'b0, upper[c*PAIR_W +: PAIR_W]} + {1'b0, lower[c*PAIR_W +: PAIR_W]};
            res[c*CH_W +: CH_W] = sum[PAIR_W:2];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/rgb_box_downsample_2x2.sv
// Top level of the 2x2 RGB box downsampler: input handling, pair sums,
// middle stage register. Depends on rbd_pkg, rbd_ctrl, rbd_line_store, rbd_out.
//
// Usage: pixels enter on the s_ channel in raster order, one item per pixel
// with red in s_tdata[7:0], green in [15:8] and blue in [23:16]. For each
// 2x2 block one averaged pixel leaves on the m_ channel in the same layout;
// m_tlast marks the last output pixel of a frame. Frame size is set through
// the cfg_ port (index 0 half width, index 1 half height, in output pixels);
// writes are always taken and belong between frames.
// Throughput is one input item per clock while s_tready is high. The pixel
// that completes a block (odd row, odd column) is registered in the line store
// read and the middle stage, then the final add loads the output register.
// Reset clears the counters, sets both sizes to one and empties the pipeline;
// the line store is not cleared, each entry is written on an even row before
// the following odd row reads it. When the receiver stalls, the output
// register holds, the middle stage fills, and s_tready drops only while both
// are occupied.
`default_nettype none

module rgb_box_downsample_2x2 #(
    parameter int MAX_HALF_WIDTH = rbd_pkg::DEF_MAX_HALF_WIDTH
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Configuration write channel.
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [rbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rbd_pkg::CFG_DATA_W-1:0] cfg_data,
    // Input pixels.
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [rbd_pkg::PIX_W-1:0]      s_tdata,  // in_red, in_green, in_blue
    // Output pixels.
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [rbd_pkg::PIX_W-1:0]           m_tdata,  // out_red, out_green, out_blue
    output logic                                m_tlast   // frame_end
);
    import rbd_pkg::*;

    localparam int CW = (MAX_HALF_WIDTH > 1) ? $clog2(MAX_HALF_WIDTH) : 1;

    rbd_pos_t           pos;
    logic [CW-1:0]      slot;
    logic               accept;
    logic [PAIRS_W-1:0] pair_reg, pair_next;
    logic               mid_valid_reg;
    logic [PAIRS_W-1:0] mid_pair_reg;
    logic               mid_last_reg;
    logic               mid_ready;
    logic [PAIRS_W-1:0] upper_pairs;
    logic               wr_en;
    logic               rd_en;

    assign cfg_ready = 1'b1;
    assign s_tready  = ~mid_valid_reg | mid_ready;
    assign accept    = s_tvalid & s_tready;

    rbd_ctrl #(
        .MAX_HALF_WIDTH(MAX_HALF_WIDTH),
        .CW            (CW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .advance  (accept),
        .pos      (pos),
        .slot     (slot)
    );

    // Horizontal pair sum: the even column starts it, the odd column adds.
    always_comb begin
        if (pos.odd_col) begin
            pair_next = pair_add(pair_reg, s_tdata);
        end else begin
            pair_next = pix_to_pairs(s_tdata);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_reg <= '0;
        end else if (accept) begin
            pair_reg <= pair_next;
        end
    end

    // Even rows store the pair; odd rows fetch the stored one.
    assign wr_en = accept & pos.odd_col & ~pos.odd_row;
    assign rd_en = accept & pos.odd_col & pos.odd_row;

    rbd_line_store #(
        .DEPTH(MAX_HALF_WIDTH),
        .AW   (CW)
    ) u_line_store (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(slot),
        .wr_data(pair_next),
        .rd_en  (rd_en),
        .rd_addr(slot),
        .rd_data(upper_pairs)
    );

    // Middle stage, aligned with the registered line store read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
        end else if (s_tready) begin
            mid_valid_reg <= rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            mid_pair_reg <= pair_next;
            mid_last_reg <= pos.last_out;
        end
    end

    rbd_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (mid_valid_reg),
        .in_ready   (mid_ready),
        .upper_pairs(upper_pairs),
        .lower_pairs(mid_pair_reg),
        .in_last    (mid_last_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

### hw/rtl/rbd_ctrl.sv
// Frame position control: size registers, column/row counters and phases.
// Depends on rbd_pkg.
`default_nettype none

module rbd_ctrl #(
    parameter int MAX_HALF_WIDTH = rbd_pkg::DEF_MAX_HALF_WIDTH,
    parameter int CW             = (MAX_HALF_WIDTH > 1) ? $clog2(MAX_HALF_WIDTH) : 1
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    input  wire logic [rbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rbd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                          advance,
    output rbd_pkg::rbd_pos_t                  pos,
    output logic [CW-1:0]                      slot
);
    import rbd_pkg::*;

    logic [HW_W-1:0] half_width_reg;
    logic [HH_W-1:0] half_height_reg;
    logic [CW-1:0]   col_count_reg, col_count_next;
    logic [HH_W-1:0] row_count_reg, row_count_next;
    logic            col_phase_reg, col_phase_next;
    logic            row_phase_reg, row_phase_next;
    logic [CW-1:0]   w_last;
    logic [HH_W-1:0] h_last;
    logic            last_col;
    logic            last_row;

    // Configuration writes; the port never stalls.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_width_reg  <= HW_W'(1);
            half_height_reg <= HH_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_HALF_WIDTH:  half_width_reg  <= cfg_data[HW_W-1:0];
                CFG_HALF_HEIGHT: half_height_reg <= cfg_data[HH_W-1:0];
                default: ;
            endcase
        end
    end

    // Last column and row index, with zero read as one and the width
    // clamped to the line store depth.
    always_comb begin
        if (half_width_reg == '0) begin
            w_last = '0;
        end else if (32'(half_width_reg) > 32'(MAX_HALF_WIDTH)) begin
            w_last = CW'(MAX_HALF_WIDTH - 1);
        end else begin
            w_last = CW'(half_width_reg - HW_W'(1));
        end
        h_last   = (half_height_reg == '0) ? '0 : half_height_reg - HH_W'(1);
        last_col = col_count_reg >= w_last;
        last_row = row_count_reg >= h_last;
    end

    // Counter advance on each accepted item.
    always_comb begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        col_phase_next = ~col_phase_reg;
        row_phase_next = row_phase_reg;
        if (col_phase_reg) begin
            if (last_col) begin
                col_count_next = '0;
                row_phase_next = ~row_phase_reg;
                if (row_phase_reg) begin
                    row_count_next = last_row ? '0 : row_count_reg + HH_W'(1);
                end
            end else begin
                col_count_next = col_count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            col_phase_reg <= 1'b0;
            row_phase_reg <= 1'b0;
        end else if (advance) begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            col_phase_reg <= col_phase_next;
            row_phase_reg <= row_phase_next;
        end
    end

    assign pos.odd_col  = col_phase_reg;
    assign pos.odd_row  = row_phase_reg;
    assign pos.last_out = last_col & last_row;
    assign slot         = col_count_reg;

endmodule

`default_nettype wire

### hw/rtl/rbd_line_store.sv
// Line store holding the even-row pair sums, one entry per output column.
// Single write port and one registered read port. Depends on rbd_pkg.
`default_nettype none

module rbd_line_store #(
    parameter int DEPTH = rbd_pkg::DEF_MAX_HALF_WIDTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                        aclk,
    input  wire logic                        wr_en,
    input  wire logic [AW-1:0]               wr_addr,
    input  wire logic [rbd_pkg::PAIRS_W-1:0] wr_data,
    input  wire logic                        rd_en,
    input  wire logic [AW-1:0]               rd_addr,
    output logic [rbd_pkg::PAIRS_W-1:0]      rd_data
);
    import rbd_pkg::*;

    logic [PAIRS_W-1:0] mem [DEPTH];
    logic [PAIRS_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hw/rtl/rbd_out.sv
// Output stage: adds the stored upper pairs to the lower pairs, divides by
// four and holds the result in the output register. Depends on rbd_pkg.
`default_nettype none

module rbd_out (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [rbd_pkg::PAIRS_W-1:0] upper_pairs,
    input  wire logic [rbd_pkg::PAIRS_W-1:0] lower_pairs,
    input  wire logic                        in_last,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [rbd_pkg::PIX_W-1:0]        m_tdata,
    output logic                             m_tlast
);
    import rbd_pkg::*;

    logic             valid_reg;
    logic [PIX_W-1:0] data_reg;
    logic             last_reg;
    logic             load;

    assign in_ready = ~valid_reg | m_tready;
    assign load     = in_valid & in_ready;

    // Output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= box_avg(upper_pairs, lower_pairs);
            last_reg <= in_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire
